// ===== hdl/efg_pkg.sv =====
// ----------------------------------------------------------------------------
// efg_pkg
// Shared types and constants of the event flag group: command codes,
// register indexes, the configuration bundle and the result bundle.
// ----------------------------------------------------------------------------
package efg_pkg;

    localparam int FLAG_W    = 64;
    localparam int MASK_REGS = 4;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 3;
    localparam int COUNT_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAISE      = 3'd0,
        CMD_DROP       = 3'd1,
        CMD_SET        = 3'd2,
        CMD_LISTEN_ALL = 3'd3,
        CMD_LISTEN_ONE = 3'd4,
        CMD_SNOOP      = 3'd5
    } cmd_e;

    localparam logic [IDX_W-1:0] REG_CONSUME = 3'd4;
    localparam logic [IDX_W-1:0] REG_COUNT   = 3'd5;

    typedef struct packed {
        logic [MASK_REGS-1:0][FLAG_W-1:0] masks;
        logic [MASK_REGS-1:0]             consume;
        logic [COUNT_W-1:0]               limit;
    } cfg_t;

    typedef struct packed {
        logic [FLAG_W-1:0]    flags_now;
        logic [MASK_REGS-1:0] fired_events;
        logic                 snoop_hit;
    } result_t;

endpackage

// ===== hdl/efg_cfg.sv =====
// ----------------------------------------------------------------------------
// efg_cfg
// Configuration register file: event masks, consume bits and the event
// count, saturated to the number of events that have a mask.
// ----------------------------------------------------------------------------
module efg_cfg
    import efg_pkg::*;
#(
    parameter int NUM_EVENTS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [FLAG_W-1:0]  cfg_data,
    output cfg_t               cfg
);

    localparam int USED = (NUM_EVENTS < MASK_REGS) ? NUM_EVENTS : MASK_REGS;
    localparam logic [COUNT_W-1:0] USED_COUNT = COUNT_W'(USED);

    logic [USED-1:0][FLAG_W-1:0] mask_reg;
    logic [MASK_REGS-1:0]        consume_reg;
    logic [COUNT_W-1:0]          count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            consume_reg <= '0;
            count_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < USED; i++)
            begin
                if (cfg_index == IDX_W'(i))
                    mask_reg[i] <= cfg_data;
            end
            if (cfg_index == REG_CONSUME)
                consume_reg <= cfg_data[MASK_REGS-1:0];
            if (cfg_index == REG_COUNT)
                count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    // events without a mask register read as disabled
    always_comb
    begin
        cfg.masks = '0;
        for (int i = 0; i < USED; i++)
            cfg.masks[i] = mask_reg[i];
        cfg.consume = consume_reg;
        cfg.limit   = (count_reg > USED_COUNT) ? USED_COUNT : count_reg;
    end

endmodule

// ===== hdl/efg_core.sv =====
// ----------------------------------------------------------------------------
// efg_core
// Flag word and pending masks, with the combinational command logic that
// updates them and forms the result of one command.
// ----------------------------------------------------------------------------
module efg_core
    import efg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [FLAG_W-1:0]  value,
    input  logic               consume_one,
    input  cfg_t               cfg,
    output result_t            res
);

    logic [FLAG_W-1:0]    flag_reg,  flag_next;
    logic [FLAG_W-1:0]    raise_reg, raise_next;
    logic [FLAG_W-1:0]    drop_reg,  drop_next;
    logic [FLAG_W-1:0]    work;
    logic [MASK_REGS-1:0] fired;
    logic                 hit;

    always_comb
    begin
        flag_next  = flag_reg;
        raise_next = raise_reg;
        drop_next  = drop_reg;
        work       = flag_reg;
        fired      = '0;
        hit        = 1'b0;
        case (cmd_e'(cmd))
            CMD_RAISE:
            begin
                raise_next = raise_reg | value;
                drop_next  = drop_reg & ~value;
            end
            CMD_DROP:
            begin
                drop_next  = drop_reg | value;
                raise_next = raise_reg & ~value;
            end
            CMD_SET:
            begin
                flag_next  = value;
                raise_next = '0;
                drop_next  = '0;
            end
            CMD_LISTEN_ALL:
            begin
                // check events in order; a consuming event hides its bits
                // from the later ones
                for (int i = 0; i < MASK_REGS; i++)
                begin
                    if (COUNT_W'(i) < cfg.limit && cfg.masks[i] != '0
                        && (work & cfg.masks[i]) == cfg.masks[i])
                    begin
                        fired[i] = 1'b1;
                        if (cfg.consume[i])
                            work = work & ~cfg.masks[i];
                    end
                end
                flag_next  = (work | raise_reg) & ~drop_reg;
                raise_next = '0;
                drop_next  = '0;
            end
            CMD_LISTEN_ONE:
            begin
                if (value != '0 && (flag_reg & value) == value)
                begin
                    fired[0] = 1'b1;
                    if (consume_one)
                        flag_next = flag_reg & ~value;
                end
                raise_next = '0;
                drop_next  = '0;
            end
            CMD_SNOOP:
            begin
                hit = ((flag_reg & value) == value);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= '0;
            raise_reg <= '0;
            drop_reg  <= '0;
        end
        else if (step)
        begin
            flag_reg  <= flag_next;
            raise_reg <= raise_next;
            drop_reg  <= drop_next;
        end
    end

    assign res.flags_now    = flag_next;
    assign res.fired_events = fired;
    assign res.snoop_hit    = hit;

endmodule

// ===== hdl/event_flag_group.sv =====
// ----------------------------------------------------------------------------
// event_flag_group
// 64-bit event flag group with queued raise/drop changes and listeners.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one command per transfer with
//   cmd, value and consume_one. Output channel (out_valid / out_stall):
//   exactly one result per command with flags_now, fired_events and
//   snoop_hit, in command order.
//   Configuration channel (cfg_valid / cfg_ready): cfg_index selects the
//   register (0..3 event masks, 4 consume bits, 5 event count), cfg_data
//   carries the value. cfg_ready is always high; write only while idle.
//   The command is held in the input register and its result loads into
//   the result register once that register frees up, raising out_valid.
//   Throughput: one command per cycle while not stalled; the flag word
//   and pending masks update in the same cycle that the command logic
//   evaluates, so each command sees the state left by the one before it.
//   A stall on the output holds the result register and, once both
//   registers are full, raises in_stall in the same cycle.
//   Reset clears the flag word, the pending masks and all configuration
//   registers; both channels come out of reset empty.
// ----------------------------------------------------------------------------
module event_flag_group
    import efg_pkg::*;
#(
    parameter int NUM_EVENTS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [FLAG_W-1:0]    value,
    input  logic                 consume_one,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [FLAG_W-1:0]    flags_now,
    output logic [MASK_REGS-1:0] fired_events,
    output logic                 snoop_hit,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [FLAG_W-1:0]    cfg_data
);

    cfg_t    cfg;
    result_t res;

    logic                in_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [FLAG_W-1:0]   value_reg;
    logic                consume_one_reg;
    logic                out_valid_reg;
    result_t             res_reg;
    logic                advance;
    logic                step;

    assign cfg_ready = 1'b1;

    // result register frees up this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign step     = in_valid_reg && advance;

    efg_cfg #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    efg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cmd         (cmd_reg),
        .value       (value_reg),
        .consume_one (consume_one_reg),
        .cfg         (cfg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg         <= cmd;
            value_reg       <= value;
            consume_one_reg <= consume_one;
        end
        if (step)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign flags_now    = res_reg.flags_now;
    assign fired_events = res_reg.fired_events;
    assign snoop_hit    = res_reg.snoop_hit;

endmodule
